[rtl/c8alu_pkg.sv]
package c8alu_pkg;

  // Operation codes
  localparam logic [5:0] OP_LDA  = 6'd0;
  localparam logic [5:0] OP_LDX  = 6'd1;
  localparam logic [5:0] OP_LDY  = 6'd2;
  localparam logic [5:0] OP_ADC  = 6'd3;
  localparam logic [5:0] OP_SBC  = 6'd4;
  localparam logic [5:0] OP_AND  = 6'd5;
  localparam logic [5:0] OP_ORA  = 6'd6;
  localparam logic [5:0] OP_EOR  = 6'd7;
  localparam logic [5:0] OP_CMP  = 6'd8;
  localparam logic [5:0] OP_CPX  = 6'd9;
  localparam logic [5:0] OP_CPY  = 6'd10;
  localparam logic [5:0] OP_BIT  = 6'd11;
  localparam logic [5:0] OP_SHF_FIRST = 6'd12; // ASL A
  localparam logic [5:0] OP_SHF_LAST  = 6'd19; // ROR M
  localparam logic [5:0] OP_INC  = 6'd20;
  localparam logic [5:0] OP_DEC  = 6'd21;
  localparam logic [5:0] OP_INX  = 6'd22;
  localparam logic [5:0] OP_INY  = 6'd23;
  localparam logic [5:0] OP_DEX  = 6'd24;
  localparam logic [5:0] OP_DEY  = 6'd25;
  localparam logic [5:0] OP_TAX  = 6'd26;
  localparam logic [5:0] OP_TAY  = 6'd27;
  localparam logic [5:0] OP_TXA  = 6'd28;
  localparam logic [5:0] OP_TYA  = 6'd29;
  localparam logic [5:0] OP_CLC  = 6'd30;
  localparam logic [5:0] OP_SEC  = 6'd31;
  localparam logic [5:0] OP_CLI  = 6'd32;
  localparam logic [5:0] OP_SEI  = 6'd33;
  localparam logic [5:0] OP_CLD  = 6'd34;
  localparam logic [5:0] OP_SED  = 6'd35;
  localparam logic [5:0] OP_CLV  = 6'd36;
  localparam logic [5:0] OP_STA  = 6'd37;
  localparam logic [5:0] OP_STX  = 6'd38;
  localparam logic [5:0] OP_STY  = 6'd39;
  localparam logic [5:0] OP_PHA  = 6'd40;
  localparam logic [5:0] OP_PHP  = 6'd41;
  localparam logic [5:0] OP_PLA  = 6'd42;
  localparam logic [5:0] OP_PLP  = 6'd43;
  localparam logic [5:0] OP_BPL  = 6'd44;
  localparam logic [5:0] OP_BMI  = 6'd45;
  localparam logic [5:0] OP_BVC  = 6'd46;
  localparam logic [5:0] OP_BVS  = 6'd47;
  localparam logic [5:0] OP_BCC  = 6'd48;
  localparam logic [5:0] OP_BCS  = 6'd49;
  localparam logic [5:0] OP_BNE  = 6'd50;
  localparam logic [5:0] OP_BEQ  = 6'd51;

  // Shift kinds, from (code - first shift code) >> 1
  localparam logic [1:0] SHF_ASL = 2'd0;
  localparam logic [1:0] SHF_LSR = 2'd1;
  localparam logic [1:0] SHF_ROL = 2'd2;
  localparam logic [1:0] SHF_ROR = 2'd3;

  // Status bit positions
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  localparam logic [7:0] STATUS_RESET = 8'h34;

  // Stream widths and result field positions in the output tdata
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_SV_LO  = 32;
  localparam int OUT_SV_HI  = 39;
  localparam int OUT_ST_BIT = 40;
  localparam int OUT_BR_BIT = 41;

endpackage

[rtl/cpu8_alu_execute_unit.sv]
// Execute unit of an 8-bit 6502-style processor (binary arithmetic).
// Input stream s_axis: one transfer carries an operation code and its operand
// byte (memory, immediate or pulled stack byte). The unit holds A, X, Y and
// the status byte and updates them as each transfer is accepted.
// Output stream m_axis: one transfer per input, carrying A, X, Y and status
// after the operation, a store byte with its valid bit, and the branch flag.
// Each result is registered in the output register, or in the skid register if stalled.
// Throughput: one operation per cycle while s_axis_tready is high; the work is a single 8-bit add, logic
// op or shift plus flag logic between the input and the output register.
// Stall: an output register and a one-deep skid register sit behind the
// logic, so an input is still taken while a result waits; s_axis_tready drops
// only when both hold results, and recovers the cycle after m_axis_tready.
// Reset (rst, synchronous, active high): A, X, Y cleared, status = 0x34,
// output and skid registers emptied.
module cpu8_alu_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] func, [13:6] operand, [15:14] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [7:0] acc_out, [15:8] x_out, [23:16] y_out,
                                      // [31:24] flags_out, [39:32] store_value,
                                      // [40] store_valid, [41] branch_taken,
                                      // [47:42] zero
);

  // Architectural registers
  logic [7:0] acc, idx_x, idx_y, status;
  logic [7:0] acc_next, idx_x_next, idx_y_next, status_next;

  // Output register and skid register
  logic [c8alu_pkg::OUT_DATA_W-1:0] out_data, skid_data;
  logic                             skid_valid;

  logic [5:0] func;
  logic [7:0] operand;
  logic       in_xfer, out_free;

  // Per-operation datapath
  logic [7:0] zn_val;
  logic       zn_en;
  logic [7:0] store_val;
  logic       store_en;
  logic       branch;
  logic [7:0] add_b;
  logic [8:0] add_sum;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [5:0] shf_sel;
  logic [7:0] shf_src, shf_res;
  logic       shf_cout;
  logic [c8alu_pkg::OUT_DATA_W-1:0] result;

  assign func    = s_axis_tdata[5:0];
  assign operand = s_axis_tdata[13:6];

  assign s_axis_tready = !skid_valid;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // ADC / SBC share one adder; SBC adds the inverted operand
  assign add_b   = (func == c8alu_pkg::OP_SBC) ? ~operand : operand;
  assign add_sum = {1'b0, acc} + {1'b0, add_b} + {8'd0, status[c8alu_pkg::FLAG_C]};

  // Compare: reg + ~M + 1, carry out means reg >= M
  always_comb begin
    case (func)
      c8alu_pkg::OP_CPX: cmp_reg = idx_x;
      c8alu_pkg::OP_CPY: cmp_reg = idx_y;
      default:           cmp_reg = acc;
    endcase
  end
  assign cmp_diff = {1'b0, cmp_reg} + {1'b0, ~operand} + 9'd1;

  // Shifts and rotates: odd codes work on memory, even on A
  assign shf_sel = func - c8alu_pkg::OP_SHF_FIRST;
  assign shf_src = func[0] ? operand : acc;

  always_comb begin
    case (shf_sel[2:1])
      c8alu_pkg::SHF_ASL: begin
        shf_res  = {shf_src[6:0], 1'b0};
        shf_cout = shf_src[7];
      end
      c8alu_pkg::SHF_LSR: begin
        shf_res  = {1'b0, shf_src[7:1]};
        shf_cout = shf_src[0];
      end
      c8alu_pkg::SHF_ROL: begin
        shf_res  = {shf_src[6:0], status[c8alu_pkg::FLAG_C]};
        shf_cout = shf_src[7];
      end
      default: begin
        shf_res  = {status[c8alu_pkg::FLAG_C], shf_src[7:1]};
        shf_cout = shf_src[0];
      end
    endcase
  end

  always_comb begin
    acc_next    = acc;
    idx_x_next  = idx_x;
    idx_y_next  = idx_y;
    status_next = status;
    zn_val      = 8'd0;
    zn_en       = 1'b0;
    store_val   = 8'd0;
    store_en    = 1'b0;
    branch      = 1'b0;

    if (func inside {[c8alu_pkg::OP_SHF_FIRST:c8alu_pkg::OP_SHF_LAST]}) begin
      status_next[c8alu_pkg::FLAG_C] = shf_cout;
      zn_val = shf_res;
      zn_en  = 1'b1;
      if (func[0]) begin
        store_val = shf_res;
        store_en  = 1'b1;
      end else begin
        acc_next = shf_res;
      end
    end else begin
      case (func)
        c8alu_pkg::OP_LDA, c8alu_pkg::OP_PLA: begin
          acc_next = operand; zn_val = operand; zn_en = 1'b1;
        end
        c8alu_pkg::OP_LDX: begin
          idx_x_next = operand; zn_val = operand; zn_en = 1'b1;
        end
        c8alu_pkg::OP_LDY: begin
          idx_y_next = operand; zn_val = operand; zn_en = 1'b1;
        end
        c8alu_pkg::OP_ADC, c8alu_pkg::OP_SBC: begin
          acc_next = add_sum[7:0];
          status_next[c8alu_pkg::FLAG_C] = add_sum[8];
          // signed overflow: both inputs differ in sign from the result
          status_next[c8alu_pkg::FLAG_V] = (acc[7] ^ add_sum[7]) & (add_b[7] ^ add_sum[7]);
          zn_val = add_sum[7:0]; zn_en = 1'b1;
        end
        c8alu_pkg::OP_AND: begin
          acc_next = acc & operand; zn_val = acc & operand; zn_en = 1'b1;
        end
        c8alu_pkg::OP_ORA: begin
          acc_next = acc | operand; zn_val = acc | operand; zn_en = 1'b1;
        end
        c8alu_pkg::OP_EOR: begin
          acc_next = acc ^ operand; zn_val = acc ^ operand; zn_en = 1'b1;
        end
        c8alu_pkg::OP_CMP, c8alu_pkg::OP_CPX, c8alu_pkg::OP_CPY: begin
          status_next[c8alu_pkg::FLAG_C] = cmp_diff[8];
          zn_val = cmp_diff[7:0]; zn_en = 1'b1;
        end
        c8alu_pkg::OP_BIT: begin
          status_next[c8alu_pkg::FLAG_N] = operand[7];
          status_next[c8alu_pkg::FLAG_V] = operand[6];
          status_next[c8alu_pkg::FLAG_Z] = ((acc & operand) == 8'd0);
        end
        c8alu_pkg::OP_INC: begin
          store_val = operand + 8'd1; store_en = 1'b1;
          zn_val = operand + 8'd1; zn_en = 1'b1;
        end
        c8alu_pkg::OP_DEC: begin
          store_val = operand - 8'd1; store_en = 1'b1;
          zn_val = operand - 8'd1; zn_en = 1'b1;
        end
        c8alu_pkg::OP_INX: begin
          idx_x_next = idx_x + 8'd1; zn_val = idx_x + 8'd1; zn_en = 1'b1;
        end
        c8alu_pkg::OP_INY: begin
          idx_y_next = idx_y + 8'd1; zn_val = idx_y + 8'd1; zn_en = 1'b1;
        end
        c8alu_pkg::OP_DEX: begin
          idx_x_next = idx_x - 8'd1; zn_val = idx_x - 8'd1; zn_en = 1'b1;
        end
        c8alu_pkg::OP_DEY: begin
          idx_y_next = idx_y - 8'd1; zn_val = idx_y - 8'd1; zn_en = 1'b1;
        end
        c8alu_pkg::OP_TAX: begin
          idx_x_next = acc; zn_val = acc; zn_en = 1'b1;
        end
        c8alu_pkg::OP_TAY: begin
          idx_y_next = acc; zn_val = acc; zn_en = 1'b1;
        end
        c8alu_pkg::OP_TXA: begin
          acc_next = idx_x; zn_val = idx_x; zn_en = 1'b1;
        end
        c8alu_pkg::OP_TYA: begin
          acc_next = idx_y; zn_val = idx_y; zn_en = 1'b1;
        end
        c8alu_pkg::OP_CLC: status_next[c8alu_pkg::FLAG_C] = 1'b0;
        c8alu_pkg::OP_SEC: status_next[c8alu_pkg::FLAG_C] = 1'b1;
        c8alu_pkg::OP_CLI: status_next[c8alu_pkg::FLAG_I] = 1'b0;
        c8alu_pkg::OP_SEI: status_next[c8alu_pkg::FLAG_I] = 1'b1;
        c8alu_pkg::OP_CLD: status_next[c8alu_pkg::FLAG_D] = 1'b0;
        c8alu_pkg::OP_SED: status_next[c8alu_pkg::FLAG_D] = 1'b1;
        c8alu_pkg::OP_CLV: status_next[c8alu_pkg::FLAG_V] = 1'b0;
        c8alu_pkg::OP_STA, c8alu_pkg::OP_PHA: begin
          store_val = acc; store_en = 1'b1;
        end
        c8alu_pkg::OP_STX: begin
          store_val = idx_x; store_en = 1'b1;
        end
        c8alu_pkg::OP_STY: begin
          store_val = idx_y; store_en = 1'b1;
        end
        c8alu_pkg::OP_PHP: begin
          store_val = status; store_en = 1'b1;
        end
        c8alu_pkg::OP_PLP: status_next = operand;
        c8alu_pkg::OP_BPL: branch = !status[c8alu_pkg::FLAG_N];
        c8alu_pkg::OP_BMI: branch =  status[c8alu_pkg::FLAG_N];
        c8alu_pkg::OP_BVC: branch = !status[c8alu_pkg::FLAG_V];
        c8alu_pkg::OP_BVS: branch =  status[c8alu_pkg::FLAG_V];
        c8alu_pkg::OP_BCC: branch = !status[c8alu_pkg::FLAG_C];
        c8alu_pkg::OP_BCS: branch =  status[c8alu_pkg::FLAG_C];
        c8alu_pkg::OP_BNE: branch = !status[c8alu_pkg::FLAG_Z];
        c8alu_pkg::OP_BEQ: branch =  status[c8alu_pkg::FLAG_Z];
        default: ; // unused codes: no operation
      endcase
    end

    if (zn_en) begin
      status_next[c8alu_pkg::FLAG_Z] = (zn_val == 8'd0);
      status_next[c8alu_pkg::FLAG_N] = zn_val[7];
    end
  end

  assign result = {6'd0, branch, store_en, store_val,
                   status_next, idx_y_next, idx_x_next, acc_next};

  // Register state on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= 8'd0;
      idx_x  <= 8'd0;
      idx_y  <= 8'd0;
      status <= c8alu_pkg::STATUS_RESET;
    end else if (in_xfer) begin
      acc    <= acc_next;
      idx_x  <= idx_x_next;
      idx_y  <= idx_y_next;
      status <= status_next;
    end
  end

  // Output register with skid: new result goes straight out when the output
  // register is free, otherwise parks in the skid until the output drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_xfer || skid_valid;
      skid_valid    <= 1'b0;
    end else if (in_xfer) begin
      skid_valid    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : result;
    end
    if (in_xfer && !out_free) begin
      skid_data <= result;
    end
  end

  assign m_axis_tdata = out_data;

endmodule

[rtl/c8alu_checker.sv]
module c8alu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Input only backs up when a result is already waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // Every accepted input yields a result next cycle unless one is stalled
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("accepted input produced no result");

  // Store byte is zero without a store, and a store is never a taken branch
  a_store_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[c8alu_pkg::OUT_ST_BIT] ||
       m_axis_tdata[c8alu_pkg::OUT_SV_HI:c8alu_pkg::OUT_SV_LO] == 8'd0) &&
      !(m_axis_tdata[c8alu_pkg::OUT_ST_BIT] && m_axis_tdata[c8alu_pkg::OUT_BR_BIT]))
    else $error("inconsistent store or branch fields");

endmodule

bind cpu8_alu_execute_unit c8alu_checker u_c8alu_checker (.*);
